// File: rtl/equal_population_depth_thresholds_macros.svh
`ifndef EQUAL_POPULATION_DEPTH_THRESHOLDS_MACROS_SVH
`define EQUAL_POPULATION_DEPTH_THRESHOLDS_MACROS_SVH

// same-cycle implication
`define EPDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EPDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/epdt_pkg.sv
`timescale 1ns / 1ps
package epdt_pkg;

  localparam int DEPTH_W = 20;
  localparam int LEVEL_W = 4;
  localparam int BIN_W = 7;
  localparam int SQ_W = 40;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_index;
    logic [BIN_W-1:0]   bin_index;
    logic [SQ_W-1:0]    threshold_sq;
    logic               overflow;
    logic               final_res;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_LOAD,
    ST_B_RD,
    ST_B_NUM,
    ST_B_DIV,
    ST_B_WAIT,
    ST_B_INC,
    ST_W_RD,
    ST_W_CHK,
    ST_E_DIV,
    ST_E_WAIT,
    ST_E_OUT
  } state_e;

endpackage

// File: rtl/equal_population_depth_thresholds.sv
`timescale 1ns / 1ps
// samples load at one item per cycle while busy is low; no results for a non-last item
// last item: a binning pass over the stored samples, each one through the bin divider
// then a walk over the histogram bins, with an edge divide and a result for each level
// LEVELS results, one strobe cycle each, then a histogram clear
// reset: busy while the histogram memory is swept to zero
module equal_population_depth_thresholds #(
  parameter int BINS = 64,
  parameter int LEVELS = 8,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  epdt_pkg::in_t  item_i,
  output logic           res_valid_o,
  output epdt_pkg::out_t res_o
);

  import epdt_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int BW = $clog2(BINS);
  localparam int NBW = $clog2(BINS + LEVELS + 1);
  localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QTW = CW + 5;
  localparam int BDW = DEPTH_W + 1;
  localparam int BRW = BDW + BW;
  localparam int EQW = NBW + DEPTH_W;
  localparam int ESH = EQW + $clog2(BINS - 1);
  localparam int RCW = ESH - $clog2(BINS) + 2;
  localparam int EMW = EQW + RCW;
  // reciprocal of BINS-1, exact for every product below 2**EQW
  localparam logic [RCW-1:0] EREC =
    RCW'(((64'd1 << ESH) + 64'(BINS - 2)) / 64'(BINS - 1));

  state_e state_q, state_d;

  logic [DEPTH_W-1:0] store_mem [MAX_SAMPLES];
  logic [CW-1:0]      bin_mem [BINS];
  logic [DEPTH_W-1:0] store_rd_q;
  logic [CW-1:0]      bin_rd_q;

  logic [CW-1:0]      cnt_q;
  logic [DEPTH_W-1:0] mx_q;
  logic               drop_q;
  logic [CW-1:0]      bi_q;
  logic [BW-1:0]      clr_q;
  logic [NBW-1:0]     n_q;
  logic [LVW-1:0]     lvl_q;
  logic [CW-1:0]      area_q;
  logic [QTW-1:0]     quota_q;
  logic [BW-1:0]      bin_q;
  logic [BRW-1:0]     bnum_q;
  logic [EQW-1:0]     eprod_q;
  logic [DEPTH_W-1:0] edge_q;
  logic               res_valid_q;
  out_t               res_q;

  logic               accept;
  logic               room;
  logic               bdiv_start, bdiv_done;
  logic [BW-1:0]      bdiv_quo;
  logic [EMW-1:0]     emul;
  logic [EQW-1:0]     equo;
  logic [BW-1:0]      bin_new;
  logic [BW-1:0]      bin_raddr;
  logic               bin_we;
  logic [BW-1:0]      bin_waddr;
  logic [CW-1:0]      bin_wdata;
  logic [CW-1:0]      area_d;
  logic               hit;
  logic               in_range;
  logic               last_lvl;

  assign busy     = state_q != ST_LOAD;
  assign accept   = start && !busy;
  assign room     = cnt_q < CW'(MAX_SAMPLES);
  assign area_d   = area_q + bin_rd_q;
  assign hit      = (QTW'(area_d) * QTW'(LEVELS + 1)) > quota_q;
  assign in_range = n_q < NBW'(BINS);
  assign last_lvl = lvl_q == LVW'(LEVELS - 1);
  assign emul     = EMW'(eprod_q) * EMW'(EREC);
  assign equo     = EQW'(emul >> ESH);

  always_comb begin
    if (mx_q == '0) begin
      bin_new = '0;
    end else if (bdiv_quo > BW'(BINS - 1)) begin
      bin_new = BW'(BINS - 1);
    end else begin
      bin_new = bdiv_quo;
    end
  end

  epdt_div #(.DW(BDW), .QW(BW)) u_bdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bdiv_start),
    .num_i   (bnum_q),
    .den_i   ({mx_q, 1'b0}),
    .done_o  (bdiv_done),
    .quo_o   (bdiv_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    bdiv_start = 1'b0;
    bin_we     = 1'b0;
    bin_waddr  = clr_q;
    bin_wdata  = '0;
    bin_raddr  = bin_new;
    unique case (state_q)
      ST_CLR: begin
        bin_we = 1'b1;
        if (clr_q == BW'(BINS - 1)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (accept && item_i.last) begin
          state_d = ST_B_RD;
        end
      end
      ST_B_RD: begin
        state_d = (bi_q == cnt_q) ? ST_W_RD : ST_B_NUM;
      end
      ST_B_NUM: begin
        state_d = ST_B_DIV;
      end
      ST_B_DIV: begin
        bdiv_start = 1'b1;
        state_d    = ST_B_WAIT;
      end
      ST_B_WAIT: begin
        if (bdiv_done) begin
          state_d = ST_B_INC;
        end
      end
      ST_B_INC: begin
        bin_we    = 1'b1;
        bin_waddr = bin_q;
        bin_wdata = bin_rd_q + CW'(1);
        state_d   = ST_B_RD;
      end
      ST_W_RD: begin
        bin_raddr = n_q[BW-1:0];
        state_d   = in_range ? ST_W_CHK : ST_E_DIV;
      end
      ST_W_CHK: begin
        state_d = hit ? ST_E_DIV : ST_W_RD;
      end
      ST_E_DIV: begin
        state_d = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        state_d = ST_E_OUT;
      end
      ST_E_OUT: begin
        state_d = last_lvl ? ST_CLR : ST_W_RD;
      end
      default: begin
        state_d = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && accept && room) begin
      store_mem[cnt_q[SAW-1:0]] <= item_i.depth;
    end
    store_rd_q <= store_mem[bi_q[SAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    bin_rd_q <= bin_mem[bin_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mx_q        <= '0;
      drop_q      <= 1'b0;
      bi_q        <= '0;
      clr_q       <= '0;
      n_q         <= '0;
      lvl_q       <= '0;
      area_q      <= '0;
      quota_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLR: begin
          clr_q <= (clr_q == BW'(BINS - 1)) ? '0 : clr_q + BW'(1);
        end
        ST_LOAD: begin
          bi_q <= '0;
          if (accept) begin
            if (room) begin
              cnt_q <= cnt_q + CW'(1);
              if (item_i.depth > mx_q) begin
                mx_q <= item_i.depth;
              end
            end else begin
              drop_q <= 1'b1;
            end
          end
        end
        ST_B_RD: begin
          n_q     <= '0;
          lvl_q   <= '0;
          area_q  <= '0;
          quota_q <= QTW'(cnt_q);
        end
        ST_B_INC: begin
          bi_q <= bi_q + CW'(1);
        end
        ST_W_CHK: begin
          area_q <= area_d;
          if (!hit) begin
            n_q <= n_q + NBW'(1);
          end
        end
        ST_E_OUT: begin
          res_valid_q <= 1'b1;
          n_q         <= n_q + NBW'(1);
          lvl_q       <= lvl_q + LVW'(1);
          quota_q     <= quota_q + QTW'(cnt_q);
          if (last_lvl) begin
            cnt_q  <= '0;
            mx_q   <= '0;
            drop_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_B_RD) begin
      bnum_q <= ((BRW'(store_rd_q) * BRW'(BINS - 1)) << 1) + BRW'(mx_q);
    end
    if (state_q == ST_B_NUM) begin
      bnum_q <= ((BRW'(store_rd_q) * BRW'(BINS - 1)) << 1) + BRW'(mx_q);
    end
    if (state_q == ST_B_WAIT && bdiv_done) begin
      bin_q <= bin_new;
    end
    if (state_q == ST_E_DIV) begin
      eprod_q <= EQW'(n_q) * EQW'(mx_q);
    end
    if (state_q == ST_E_WAIT) begin
      edge_q <= (equo > EQW'(DEPTH_MAX)) ? DEPTH_MAX : equo[DEPTH_W-1:0];
    end
    if (state_q == ST_E_OUT) begin
      res_q.level_index  <= LEVEL_W'(lvl_q);
      res_q.bin_index    <= BIN_W'(n_q);
      res_q.threshold_sq <= SQ_W'(edge_q) * SQ_W'(edge_q);
      res_q.overflow     <= drop_q;
      res_q.final_res    <= last_lvl;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/epdt_div.sv
`timescale 1ns / 1ps
module epdt_div #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic             done_o,
  output logic [QW-1:0]    quo_o
);

  localparam int RW = DW + QW;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rem_q;
  logic [RW-1:0]   dsh_q;
  logic [QW-1:0]   quo_q;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;
  logic            ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNTW'(QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= RW'(den_i) << (QW - 1);
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= (quo_q << 1) | QW'(ge);
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/epdt_chk.sv
`timescale 1ns / 1ps
`include "equal_population_depth_thresholds_macros.svh"
module epdt_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input epdt_pkg::in_t  item_i,
  input logic           res_valid_o,
  input epdt_pkg::out_t res_o
);

  `EPDT_ASSERT_NOW(a_res_busy, res_valid_o, busy, "result strobe while idle")
  `EPDT_ASSERT_NEXT(a_res_gap, res_valid_o, !res_valid_o, "results back to back")
  `EPDT_ASSERT_NEXT(a_load_go, start && !busy && !item_i.last, !busy, "stall after plain item")
  `EPDT_ASSERT_NEXT(a_last_go, start && !busy && item_i.last, busy, "no compute after last")
  `EPDT_ASSERT_NEXT(a_final_clr, res_valid_o && res_o.final_res, busy, "idle right after set")

endmodule

bind equal_population_depth_thresholds epdt_chk u_chk (.*);
